// ===== hdl/prd_pkg.sv =====
package prd_pkg;

    // Blob layout.
    localparam int HDR_BYTES  = 6;
    localparam int GROUP_LAST = 11;

    localparam logic [7:0] CHANNELS = 8'd3;

    // Header position and byte phase codes.
    localparam logic [2:0] HDR_POS_FORMAT  = 3'd0;
    localparam logic [2:0] HDR_POS_CHANNEL = 3'd1;
    localparam logic [2:0] HDR_POS_CNT0    = 3'd2;
    localparam logic [2:0] HDR_POS_CNT3    = 3'd5;
    localparam logic [2:0] HDR_POS_DONE    = 3'(HDR_BYTES);
    localparam logic [3:0] PHASE_LAST      = 4'(GROUP_LAST);

    // Word slots within one group.
    localparam logic [1:0] WORD_X = 2'd0;
    localparam logic [1:0] WORD_Y = 2'd1;
    localparam logic [1:0] WORD_P = 2'd2;

    // Status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TRUNC_HDR  = 3'd1;
    localparam logic [2:0] ST_BAD_FORMAT = 3'd2;
    localparam logic [2:0] ST_BAD_CHAN   = 3'd3;
    localparam logic [2:0] ST_ZERO_COUNT = 3'd4;
    localparam logic [2:0] ST_SIZE_ERR   = 3'd5;

    localparam logic [7:0] FORMAT_ID_RESET = 8'd1;

    // One result item.
    typedef struct packed {
        logic        point_valid;
        logic [31:0] x_bits;
        logic [31:0] y_bits;
        logic [31:0] pressure_bits;
        logic        done_res;
        logic [2:0]  status;
    } prd_result_t;

endpackage

// ===== hdl/point_record_deframer.sv =====
// Point record deframer.
// The blob enters one byte per transfer on the s_ channel: s_tdata carries
// the byte and s_tlast marks the final byte. A six-byte header (format byte,
// channel byte, little-endian 32-bit point count) is followed by 12-byte
// groups, each giving one point of three little-endian 32-bit words.
// A result transfer leaves on the m_ channel when a group completes a valid
// point (m_tuser high) and on the final byte (m_tlast high, status in
// m_tdata); one transfer carries both when the final byte completes a point.
// Points are sent before the status is known, so a consumer drops the points
// of a blob whose final status is nonzero.
// The expected format byte is written on the cfg_ channel; the user must
// write it only while idle, as the block itself does not enforce this.
// Throughput: one byte per cycle while s_tready is high, set by the
// combinational header and word update logic feeding the output register.
// When the receiver stalls, one further result is held in a skid entry and
// s_tready then drops until the output register drains.
// Reset clears all blob state but the word assembly registers and sets the
// expected format byte to 1; no result is pending after reset.
module point_record_deframer
    import prd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // Configuration write: expected format byte.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_data,
    // s_tdata: data_byte [7:0]
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic         s_tlast,
    // m_tdata: x_bits [31:0], y_bits [63:32], pressure_bits [95:64],
    // status [98:96], zero fill [103:99]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,
    // m_tuser: point_valid [0]
    output logic         m_tuser,
    output logic         m_tlast
);

    logic        accept;
    logic        has_result;
    prd_result_t result;
    prd_result_t out_data;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    prd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .data_byte   (s_tdata),
        .end_of_blob (s_tlast),
        .has_result  (has_result),
        .result      (result)
    );

    prd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept && has_result),
        .in_ready  (s_tready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    // Pack the result onto the master side.
    assign m_tdata = {5'd0, out_data.status, out_data.pressure_bits,
                      out_data.y_bits, out_data.x_bits};
    assign m_tuser = out_data.point_valid;
    assign m_tlast = out_data.done_res;

endmodule

// ===== hdl/prd_parser.sv =====
module prd_parser
    import prd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [7:0]  cfg_data,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        end_of_blob,
    output logic        has_result,
    output prd_result_t result
);

    logic [7:0]  format_id_reg;
    logic [2:0]  hdr_pos_reg, hdr_pos_next;
    logic [31:0] count_reg, count_next;
    logic [3:0]  phase_reg, phase_next;
    logic [31:0] points_reg, points_next;
    logic        excess_reg, excess_next;
    logic [2:0]  err_reg, err_next;
    logic [31:0] word_reg [3];
    logic [31:0] word_next [3];
    logic        emit;
    logic [2:0]  status_val;
    logic [1:0]  word_sel;
    logic [1:0]  byte_sel;
    logic [1:0]  cnt_sel;

    assign word_sel = phase_reg[3:2];
    assign byte_sel = phase_reg[1:0];
    assign cnt_sel  = 2'(hdr_pos_reg - HDR_POS_CNT0);

    // Header checks, word assembly and group completion for the current byte.
    always_comb
    begin
        hdr_pos_next = hdr_pos_reg;
        count_next   = count_reg;
        phase_next   = phase_reg;
        points_next  = points_reg;
        excess_next  = excess_reg;
        err_next     = err_reg;
        word_next    = word_reg;
        emit         = 1'b0;
        if (hdr_pos_reg < HDR_POS_DONE)
        begin
            if (hdr_pos_reg == HDR_POS_FORMAT)
            begin
                if (err_reg == ST_OK && data_byte != format_id_reg)
                    err_next = ST_BAD_FORMAT;
            end
            else if (hdr_pos_reg == HDR_POS_CHANNEL)
            begin
                if (err_reg == ST_OK && data_byte != CHANNELS)
                    err_next = ST_BAD_CHAN;
            end
            else
            begin
                count_next[8*cnt_sel +: 8] = count_reg[8*cnt_sel +: 8] | data_byte;
                if (hdr_pos_reg == HDR_POS_CNT3 && err_reg == ST_OK && count_next == 32'd0)
                    err_next = ST_ZERO_COUNT;
            end
            hdr_pos_next = hdr_pos_reg + 3'd1;
        end
        else
        begin
            if (byte_sel == 2'd0)
                word_next[word_sel] = {24'd0, data_byte};
            else
                word_next[word_sel][8*byte_sel +: 8] = data_byte;
            if (phase_reg == PHASE_LAST)
            begin
                phase_next = 4'd0;
                if (!excess_reg && points_reg < count_reg)
                begin
                    points_next = points_reg + 32'd1;
                    emit        = (err_reg == ST_OK);
                end
                else
                begin
                    excess_next = 1'b1;
                end
            end
            else
            begin
                phase_next = phase_reg + 4'd1;
            end
        end
    end

    // Final status, in order of precedence.
    always_comb
    begin
        if (hdr_pos_next < HDR_POS_DONE)
            status_val = ST_TRUNC_HDR;
        else if (err_next != ST_OK)
            status_val = err_next;
        else if (excess_next || phase_next != 4'd0 || points_next != count_next)
            status_val = ST_SIZE_ERR;
        else
            status_val = ST_OK;
    end

    // Result item for the current byte.
    always_comb
    begin
        has_result           = emit || end_of_blob;
        result.point_valid   = emit;
        result.x_bits        = emit ? word_next[WORD_X] : 32'd0;
        result.y_bits        = emit ? word_next[WORD_Y] : 32'd0;
        result.pressure_bits = emit ? word_next[WORD_P] : 32'd0;
        result.done_res      = end_of_blob;
        result.status        = end_of_blob ? status_val : ST_OK;
    end

    // Blob state; the final byte resets all of it but the format byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_id_reg <= FORMAT_ID_RESET;
            hdr_pos_reg   <= HDR_POS_FORMAT;
            count_reg     <= 32'd0;
            phase_reg     <= 4'd0;
            points_reg    <= 32'd0;
            excess_reg    <= 1'b0;
            err_reg       <= ST_OK;
        end
        else
        begin
            if (cfg_write)
                format_id_reg <= cfg_data;
            if (accept)
            begin
                if (end_of_blob)
                begin
                    hdr_pos_reg <= HDR_POS_FORMAT;
                    count_reg   <= 32'd0;
                    phase_reg   <= 4'd0;
                    points_reg  <= 32'd0;
                    excess_reg  <= 1'b0;
                    err_reg     <= ST_OK;
                end
                else
                begin
                    hdr_pos_reg <= hdr_pos_next;
                    count_reg   <= count_next;
                    phase_reg   <= phase_next;
                    points_reg  <= points_next;
                    excess_reg  <= excess_next;
                    err_reg     <= err_next;
                end
            end
        end
    end

    // Word assembly registers; every word is rewritten from its low byte up.
    always_ff @(posedge clk)
    begin
        if (accept)
            word_reg <= word_next;
    end

`ifndef NO_ASSERTIONS
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PHASE_LAST)
        else $error("byte phase out of range");
    a_phase_after_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 4'd0 |-> hdr_pos_reg == HDR_POS_DONE)
        else $error("payload phase advanced inside the header");
    a_points_bound: assert property (@(posedge clk) disable iff (!rst_n)
        points_reg <= count_reg)
        else $error("more points counted than declared");
    a_emit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> err_reg == ST_OK && !excess_reg)
        else $error("point emitted after an error or excess group");
`endif

endmodule

// ===== hdl/prd_out_buf.sv =====
module prd_out_buf
    import prd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  prd_result_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output prd_result_t out_data
);

    logic        out_valid_reg;
    logic        skid_valid_reg;
    prd_result_t out_data_reg;
    prd_result_t skid_data_reg;
    logic        take_out;

    assign take_out  = out_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Output register with one skid entry behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take_out)
                skid_valid_reg <= 1'b0;
        end
        else if (in_valid)
        begin
            if (!out_valid_reg || take_out)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (take_out)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload moves without reset.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take_out)
                out_data_reg <= skid_data_reg;
        end
        else if (in_valid)
        begin
            if (!out_valid_reg || take_out)
                out_data_reg <= in_data;
            else
                skid_data_reg <= in_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid entry filled while output was free");
    a_skid_refill: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_ready |=> out_valid_reg && !skid_valid_reg)
        else $error("skid entry not moved to output");
`endif

endmodule

// ===== verif/tb_point_record_deframer.sv =====
module tb_point_record_deframer
    import prd_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 80;
    localparam int PHASE_BYTES    = 460;
    localparam int NUM_PHASES     = 4;
    localparam int NUM_DIR_ROWS   = 31;

    localparam prd_result_t NO_REC = '0;

    // One row of the directed table: a byte, its final flag, and an optional
    // hand-written expectation.
    typedef struct packed {
        logic [7:0]  b;
        logic        fin;
        logic        typed;
        prd_result_t rec;
    } dir_row_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    // Deframer state mirrored on the testbench side.
    logic [7:0]  fmt_expected;
    logic [2:0]  hdr_pos;
    logic [31:0] count_decl;
    logic [3:0]  grp_phase;
    logic [31:0] word_buf [3];
    logic [31:0] pts_seen;
    logic        over_count;
    logic [2:0]  first_err;

    prd_result_t awaited_records [$];
    logic [7:0]  blob_q [$];
    dir_row_t    dir_rows [NUM_DIR_ROWS];

    bit          tx_idle_en;
    bit          rx_idle_en;
    bit          hold_go;
    int unsigned idle_cycles;
    int unsigned error_count;
    int unsigned bytes_sent;
    int unsigned blobs_sent;
    int unsigned points_checked;
    int unsigned cfg_writes;
    int unsigned status_seen [6];

    point_record_deframer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Returns all blob state to its idle value; the format byte is kept.
    function automatic void clear_blob_state();
        hdr_pos     = HDR_POS_FORMAT;
        count_decl  = '0;
        grp_phase   = '0;
        word_buf[0] = '0;
        word_buf[1] = '0;
        word_buf[2] = '0;
        pts_seen    = '0;
        over_count  = 1'b0;
        first_err   = ST_OK;
    endfunction

    function automatic prd_result_t done_status(input logic [2:0] st);
        prd_result_t r;
        r          = '0;
        r.done_res = 1'b1;
        r.status   = st;
        return r;
    endfunction

    // Advances the deframer by one byte and tells whether a result follows.
    function automatic void deframe_byte(input logic [7:0] b, input logic fin,
                                         output bit produced, output prd_result_t rec);
        int   sh;
        logic emit;
        rec  = '0;
        emit = 1'b0;
        if (hdr_pos < HDR_POS_DONE)
        begin
            if (hdr_pos == HDR_POS_FORMAT)
            begin
                if (first_err == ST_OK && b != fmt_expected)
                    first_err = ST_BAD_FORMAT;
            end
            else if (hdr_pos == HDR_POS_CHANNEL)
            begin
                if (first_err == ST_OK && b != CHANNELS)
                    first_err = ST_BAD_CHAN;
            end
            else
            begin
                sh = 8 * int'(hdr_pos - HDR_POS_CNT0);
                count_decl = count_decl | (32'(b) << sh);
                if (hdr_pos == HDR_POS_CNT3 && first_err == ST_OK && count_decl == 0)
                    first_err = ST_ZERO_COUNT;
            end
            hdr_pos = hdr_pos + 3'd1;
        end
        else
        begin
            // Payload: bytes fill the three words of a group little-endian.
            sh = 8 * int'(grp_phase[1:0]);
            if (grp_phase[1:0] == 2'd0)
                word_buf[grp_phase[3:2]] = 32'(b);
            else
                word_buf[grp_phase[3:2]] = word_buf[grp_phase[3:2]] | (32'(b) << sh);
            if (grp_phase == PHASE_LAST)
            begin
                grp_phase = '0;
                if (!over_count && pts_seen < count_decl)
                begin
                    pts_seen = pts_seen + 1;
                    if (first_err == ST_OK)
                    begin
                        emit              = 1'b1;
                        rec.point_valid   = 1'b1;
                        rec.x_bits        = word_buf[WORD_X];
                        rec.y_bits        = word_buf[WORD_Y];
                        rec.pressure_bits = word_buf[WORD_P];
                    end
                end
                else
                    over_count = 1'b1;
            end
            else
                grp_phase = grp_phase + 4'd1;
        end
        produced = emit || fin;
        if (fin)
        begin
            rec.done_res = 1'b1;
            if (hdr_pos < HDR_POS_DONE)
                rec.status = ST_TRUNC_HDR;
            else if (first_err != ST_OK)
                rec.status = first_err;
            else if (over_count || grp_phase != 0 || pts_seen != count_decl)
                rec.status = ST_SIZE_ERR;
            else
                rec.status = ST_OK;
            clear_blob_state();
        end
    endfunction

    // Offers one byte, waits for its transfer and records what it should cause.
    task automatic push_byte(input logic [7:0] b, input logic fin, input logic typed,
                             input prd_result_t typed_rec);
        int unsigned gap;
        bit          produced;
        prd_result_t rec;
        if (tx_idle_en && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 18);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = fin;
        do
            @(posedge clk);
        while (!s_tready);
        deframe_byte(b, fin, produced, rec);
        if (typed)
            awaited_records.insert(awaited_records.size(), typed_rec);
        else if (produced)
            awaited_records.insert(awaited_records.size(), rec);
        bytes_sent++;
        if (fin)
            blobs_sent++;
        @(negedge clk);
    endtask

    task automatic send_blob();
        for (int i = 0; i < blob_q.size(); i++)
            push_byte(blob_q[i], i == blob_q.size() - 1, 1'b0, NO_REC);
    endtask

    // Builds a random blob: mostly well formed, the rest with one or more defects.
    task automatic make_blob(input int forced_count);
        int unsigned kind;
        int unsigned groups;
        int unsigned extra;
        int unsigned hdr_len;
        logic [7:0]  fmt_b;
        logic [7:0]  chan_b;
        logic [31:0] cnt;
        blob_q.delete();
        kind    = $urandom_range(0, 99);
        fmt_b   = fmt_expected;
        chan_b  = CHANNELS;
        cnt     = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
        extra   = 0;
        hdr_len = HDR_BYTES;
        if (forced_count > 0)
            kind = 0;
        if (forced_count > 0)
            cnt = forced_count;
        groups = cnt;
        if (kind < 70)
            groups = cnt;
        else if (kind < 76)
            groups = cnt + $urandom_range(1, 2);
        else if (kind < 82)
        begin
            groups = cnt - 1;
            extra  = $urandom_range(0, 11);
        end
        else if (kind < 86)
            fmt_b = fmt_expected ^ 8'($urandom_range(1, 255));
        else if (kind < 90)
            chan_b = CHANNELS ^ 8'($urandom_range(1, 255));
        else if (kind < 93)
        begin
            cnt    = '0;
            groups = $urandom_range(0, 1);
        end
        else if (kind < 96)
        begin
            cnt    = $urandom;
            groups = $urandom_range(0, 2);
        end
        else
        begin
            hdr_len = $urandom_range(1, 5);
            groups  = 0;
            if ($urandom_range(0, 1) == 0)
                fmt_b = 8'($urandom);
        end
        blob_q.insert(blob_q.size(), fmt_b);
        blob_q.insert(blob_q.size(), chan_b);
        blob_q.insert(blob_q.size(), cnt[7:0]);
        blob_q.insert(blob_q.size(), cnt[15:8]);
        blob_q.insert(blob_q.size(), cnt[23:16]);
        blob_q.insert(blob_q.size(), cnt[31:24]);
        while (blob_q.size() > hdr_len)
            void'(blob_q.pop_back());
        repeat (groups * 12 + extra)
            blob_q.insert(blob_q.size(), 8'($urandom));
    endtask

    // Waits until every awaited result has come and the block has settled.
    task automatic wait_idle();
        while (awaited_records.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_format(input logic [7:0] v);
        cfg_valid = 1'b1;
        cfg_data  = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        fmt_expected = v;
        cfg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Receiver: random stall bursts, plus one long hold on request.
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_go)
            begin
                hold_go    = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left != 0)
            begin
                m_tready   = 1'b0;
                stall_left = stall_left - 1;
            end
            else if (rx_idle_en && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 18) - 1;
                m_tready   = 1'b0;
            end
            else
                m_tready = 1'b1;
        end
    end

    // Result checker and activity counter for the watchdog.
    initial
    begin
        prd_result_t got;
        prd_result_t exp_rec;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (m_tvalid && m_tready)
            begin
                got.point_valid   = m_tuser;
                got.x_bits        = m_tdata[31:0];
                got.y_bits        = m_tdata[63:32];
                got.pressure_bits = m_tdata[95:64];
                got.status        = m_tdata[98:96];
                got.done_res      = m_tlast;
                if (awaited_records.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result: pv=%0d x=%h y=%h p=%h done=%0d st=%0d",
                                 got.point_valid, got.x_bits, got.y_bits,
                                 got.pressure_bits, got.done_res, got.status);
                end
                else
                begin
                    exp_rec = awaited_records.pop_front();
                    if (got !== exp_rec)
                    begin
                        error_count++;
                        if (error_count <= 10)
                        begin
                            $display("mismatch: expected pv=%0d x=%h y=%h p=%h done=%0d st=%0d",
                                     exp_rec.point_valid, exp_rec.x_bits, exp_rec.y_bits,
                                     exp_rec.pressure_bits, exp_rec.done_res, exp_rec.status);
                            $display("          actual   pv=%0d x=%h y=%h p=%h done=%0d st=%0d",
                                     got.point_valid, got.x_bits, got.y_bits,
                                     got.pressure_bits, got.done_res, got.status);
                        end
                    end
                    if (exp_rec.point_valid)
                        points_checked++;
                    if (exp_rec.done_res && exp_rec.status <= ST_SIZE_ERR)
                        status_seen[exp_rec.status]++;
                end
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    initial
    begin
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("watchdog expired after %0d quiet cycles", idle_cycles);
        $display("tb_point_record_deframer failed");
        $finish;
    end

    // Main sequence.
    initial
    begin
        int unsigned phase_start;
        logic [7:0]  phase_fmt;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        tx_idle_en  = 1'b1;
        rx_idle_en  = 1'b1;
        hold_go     = 1'b0;
        error_count = 0;
        bytes_sent  = 0;
        blobs_sent  = 0;
        cfg_writes  = 0;
        points_checked = 0;
        for (int i = 0; i < 6; i++)
            status_seen[i] = 0;
        fmt_expected = FORMAT_ID_RESET;
        clear_blob_state();

        // Directed blobs under the reset format byte: a one-byte blob, a bad
        // format that also has a bad channel and zero count, a bad channel with
        // the largest count, and a good one-point blob ending on its last byte.
        dir_rows = '{
            '{8'h01, 1'b1, 1'b1, done_status(ST_TRUNC_HDR)},
            '{8'h00, 1'b0, 1'b0, NO_REC},
            '{8'hFF, 1'b0, 1'b0, NO_REC},
            '{8'h00, 1'b0, 1'b0, NO_REC},
            '{8'h00, 1'b0, 1'b0, NO_REC},
            '{8'h00, 1'b0, 1'b0, NO_REC},
            '{8'h00, 1'b1, 1'b1, done_status(ST_BAD_FORMAT)},
            '{8'h01, 1'b0, 1'b0, NO_REC},
            '{8'h00, 1'b0, 1'b0, NO_REC},
            '{8'hFF, 1'b0, 1'b0, NO_REC},
            '{8'hFF, 1'b0, 1'b0, NO_REC},
            '{8'hFF, 1'b0, 1'b0, NO_REC},
            '{8'hFF, 1'b1, 1'b1, done_status(ST_BAD_CHAN)},
            '{8'h01, 1'b0, 1'b0, NO_REC},
            '{8'h03, 1'b0, 1'b0, NO_REC},
            '{8'h01, 1'b0, 1'b0, NO_REC},
            '{8'h00, 1'b0, 1'b0, NO_REC},
            '{8'h00, 1'b0, 1'b0, NO_REC},
            '{8'h00, 1'b0, 1'b0, NO_REC},
            '{8'hFF, 1'b0, 1'b0, NO_REC},
            '{8'hFF, 1'b0, 1'b0, NO_REC},
            '{8'hFF, 1'b0, 1'b0, NO_REC},
            '{8'hFF, 1'b0, 1'b0, NO_REC},
            '{8'h00, 1'b0, 1'b0, NO_REC},
            '{8'h00, 1'b0, 1'b0, NO_REC},
            '{8'h00, 1'b0, 1'b0, NO_REC},
            '{8'h00, 1'b0, 1'b0, NO_REC},
            '{8'h78, 1'b0, 1'b0, NO_REC},
            '{8'h56, 1'b0, 1'b0, NO_REC},
            '{8'h34, 1'b0, 1'b0, NO_REC},
            '{8'h12, 1'b1, 1'b0, NO_REC}
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < NUM_DIR_ROWS; i++)
            push_byte(dir_rows[i].b, dir_rows[i].fin, dir_rows[i].typed, dir_rows[i].rec);
        s_tvalid = 1'b0;

        // Random phases, each under its own format byte.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_idle();
            unique case (ph)
                0:       phase_fmt = 8'h00;
                1:       phase_fmt = 8'hFF;
                default: phase_fmt = 8'($urandom);
            endcase
            write_format(phase_fmt);
            if (ph == NUM_PHASES - 1)
            begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            phase_start = bytes_sent;
            if (ph == 1)
            begin
                // Long receiver hold while a long blob streams in back to back.
                tx_idle_en = 1'b0;
                hold_go    = 1'b1;
                make_blob(8);
                send_blob();
                tx_idle_en = 1'b1;
            end
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                make_blob(0);
                send_blob();
            end
            s_tvalid = 1'b0;
        end

        while (awaited_records.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d bytes in %0d blobs under %0d written format bytes; %0d points checked.",
                 bytes_sent, blobs_sent, cfg_writes, points_checked);
        $display("Final status counts ok/trunc/format/chan/zero/size: %0d/%0d/%0d/%0d/%0d/%0d",
                 status_seen[0], status_seen[1], status_seen[2],
                 status_seen[3], status_seen[4], status_seen[5]);
        if (error_count == 0 && awaited_records.size() == 0)
            $display("tb_point_record_deframer passed");
        else
            $display("tb_point_record_deframer failed");
        $finish;
    end

endmodule
